FILE: design/sdsh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdsh_pkg;

    localparam int BLOCK_BYTES = 512;
    localparam int ID_BYTES    = 16;
    localparam int BC_W = ($clog2(BLOCK_BYTES + 1) > 8) ? $clog2(BLOCK_BYTES + 1) : 8;

    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [7:0] START_TOKEN = 8'hFE;
    localparam logic [7:0] CMD_PREFIX  = 8'h40;
    localparam logic [7:0] CRC_CMD0    = 8'h95;
    localparam logic [7:0] DRESP_MASK  = 8'h1F;
    localparam logic [7:0] DRESP_OK    = 8'h05;

    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_SEND_OP    = 6'd1;
    localparam logic [5:0] CMD_SEND_CID   = 6'd10;
    localparam logic [5:0] CMD_SET_BLKLEN = 6'd16;
    localparam logic [5:0] CMD_READ_BLOCK = 6'd17;
    localparam logic [5:0] CMD_WRITE_BLK  = 6'd24;
    localparam logic [5:0] CMD_CRC_ON_OFF = 6'd59;

    localparam logic [2:0] REQ_INIT  = 3'd1;
    localparam logic [2:0] REQ_READ  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_CID   = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SAME_SEC  = 3'd1;
    localparam logic [2:0] ST_CMD0_FAIL = 3'd2;
    localparam logic [2:0] ST_CMD1_FAIL = 3'd3;
    localparam logic [2:0] ST_WCMD_FAIL = 3'd4;
    localparam logic [2:0] ST_DATA_REJ  = 3'd5;

    localparam logic [2:0] REG_CMD0_LIM = 3'd0;
    localparam logic [2:0] REG_CMD1_LIM = 3'd1;
    localparam logic [2:0] REG_POLL_LIM = 3'd2;
    localparam logic [2:0] REG_WCMD_LIM = 3'd3;
    localparam logic [2:0] REG_ID_LIM   = 3'd4;
    localparam logic [2:0] REG_CLK_BYTES = 3'd5;

    typedef enum logic [3:0] {
        PH_IDLE, PH_ICLK, PH_ICMD0, PH_CMD, PH_RESP, PH_TOKEN, PH_IDTOK,
        PH_DATA, PH_RCRC, PH_RDONE, PH_WPRE, PH_WDATA, PH_WCRC, PH_WRESP,
        PH_WBUSY
    } phase_t;

    typedef struct packed {
        phase_t          phase;
        logic [15:0]     retry_count;
        logic [BC_W-1:0] byte_count;
        logic [31:0]     last_sector;
        logic [31:0]     current_sector;
        logic [5:0]      current_command;
        logic [7:0]      saved_reply;
    } seq_state_t;

    typedef struct packed {
        logic [7:0]  cmd0_attempt_limit;
        logic [7:0]  cmd1_attempt_limit;
        logic [7:0]  response_poll_limit;
        logic [7:0]  write_command_limit;
        logic [15:0] id_token_poll_limit;
        logic [7:0]  init_clock_bytes;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  request;
        logic [31:0] sector;
        logic [7:0]  write_byte;
        logic [7:0]  miso_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] mosi_byte;
        logic       card_select;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       byte_taken;
        logic       done_res;
        logic [2:0] status;
        logic [7:0] response;
        logic       busy_res;
    } result_t;

endpackage

`default_nettype wire

FILE: design/sdsh_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sdsh_cfg_regs
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output sdsh_pkg::cfg_t    cfg
);
    import sdsh_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cmd0_attempt_limit  <= 8'd200;
            cfg_reg.cmd1_attempt_limit  <= 8'd100;
            cfg_reg.response_poll_limit <= 8'd100;
            cfg_reg.write_command_limit <= 8'd10;
            cfg_reg.id_token_poll_limit <= 16'hFFFF;
            cfg_reg.init_clock_bytes    <= 8'd255;
        end
        else if (wr_en)
        begin
            case (index)
                REG_CMD0_LIM:  cfg_reg.cmd0_attempt_limit  <= pwdata[7:0];
                REG_CMD1_LIM:  cfg_reg.cmd1_attempt_limit  <= pwdata[7:0];
                REG_POLL_LIM:  cfg_reg.response_poll_limit <= pwdata[7:0];
                REG_WCMD_LIM:  cfg_reg.write_command_limit <= pwdata[7:0];
                REG_ID_LIM:    cfg_reg.id_token_poll_limit <= pwdata[15:0];
                REG_CLK_BYTES: cfg_reg.init_clock_bytes    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_CMD0_LIM:  prdata = {24'd0, cfg_reg.cmd0_attempt_limit};
            REG_CMD1_LIM:  prdata = {24'd0, cfg_reg.cmd1_attempt_limit};
            REG_POLL_LIM:  prdata = {24'd0, cfg_reg.response_poll_limit};
            REG_WCMD_LIM:  prdata = {24'd0, cfg_reg.write_command_limit};
            REG_ID_LIM:    prdata = {16'd0, cfg_reg.id_token_poll_limit};
            REG_CLK_BYTES: prdata = {24'd0, cfg_reg.init_clock_bytes};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

FILE: design/sdsh_step.sv
`timescale 1ns / 1ps
`default_nettype none

module sdsh_step
(
    input  wire sdsh_pkg::seq_state_t state,
    input  wire sdsh_pkg::cfg_t       cfg,
    input  wire sdsh_pkg::item_t      item,
    output sdsh_pkg::seq_state_t      state_next,
    output sdsh_pkg::result_t         result
);
    import sdsh_pkg::*;

    localparam logic [BC_W-1:0] BC_ONE   = BC_W'(1);
    localparam logic [BC_W-1:0] BLK_LEN  = BC_W'(BLOCK_BYTES);
    localparam logic [BC_W-1:0] ID_LEN   = BC_W'(ID_BYTES);
    localparam logic [31:0]     BLK_ARG  = 32'(BLOCK_BYTES);

    seq_state_t s;
    result_t    r;
    logic       do_send;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  miso;
    logic [7:0]  cnt8;

    always_comb
    begin
        s       = state;
        miso    = item.miso_byte;
        do_send = 1'b0;
        arg     = 32'd0;
        crc     = IDLE_BYTE;
        cnt8    = 8'd0;

        r.mosi_byte   = IDLE_BYTE;
        r.card_select = 1'b1;
        r.data_valid  = 1'b0;
        r.data_byte   = 8'd0;
        r.byte_taken  = 1'b0;
        r.done_res    = 1'b0;
        r.status      = ST_OK;
        r.busy_res    = 1'b1;
        r.response    = 8'd0;

        // Starting a command sends its first slot: 0xFF with select released.
        case (state.phase)
            PH_IDLE:
            begin
                case (item.request)
                    REQ_INIT:
                    begin
                        s.byte_count = '0;
                        s.phase      = PH_ICLK;
                        do_send      = 1'b1;
                    end
                    REQ_READ:
                    begin
                        if (item.sector == state.last_sector)
                        begin
                            r.card_select = 1'b0; r.done_res = 1'b1;
                            r.status = ST_SAME_SEC; r.busy_res = 1'b0;
                            s.phase = PH_IDLE; s.byte_count = '0;
                        end
                        else
                        begin
                            s.last_sector     = item.sector;
                            s.current_sector  = {item.sector[22:0], 9'd0};
                            s.current_command = CMD_READ_BLOCK;
                            s.phase = PH_CMD; s.byte_count = BC_ONE;
                            r.card_select = 1'b0;
                        end
                    end
                    REQ_WRITE:
                    begin
                        s.current_sector  = {item.sector[22:0], 9'd0};
                        s.retry_count     = 16'd0;
                        s.current_command = CMD_WRITE_BLK;
                        s.phase = PH_CMD; s.byte_count = BC_ONE;
                        r.card_select = 1'b0;
                    end
                    REQ_CID:
                    begin
                        s.current_command = CMD_SEND_CID;
                        s.phase = PH_CMD; s.byte_count = BC_ONE;
                        r.card_select = 1'b0;
                    end
                    default:
                    begin
                        r.card_select = 1'b0;
                        r.busy_res    = 1'b0;
                    end
                endcase
            end
            PH_RESP:
            begin
                s.byte_count = state.byte_count + BC_ONE;
                if (miso == IDLE_BYTE && s.byte_count < BC_W'(cfg.response_poll_limit))
                begin
                    s.phase = PH_RESP;
                end
                else
                begin
                    s.saved_reply = miso;
                    case (state.current_command)
                        CMD_GO_IDLE:
                        begin
                            cnt8 = state.retry_count[7:0] + 8'd1;
                            s.retry_count = {8'd0, cnt8};
                            if (cnt8 == cfg.cmd0_attempt_limit)
                            begin
                                r.card_select = 1'b0; r.done_res = 1'b1;
                                r.status = ST_CMD0_FAIL; r.busy_res = 1'b0;
                                s.phase = PH_IDLE; s.byte_count = '0;
                            end
                            else
                            begin
                                if (miso == 8'd1)
                                begin
                                    s.retry_count = 16'd0;
                                    s.current_command = CMD_SEND_OP;
                                end
                                else
                                begin
                                    s.current_command = CMD_GO_IDLE;
                                end
                                s.phase = PH_CMD; s.byte_count = BC_ONE;
                                r.card_select = 1'b0;
                            end
                        end
                        CMD_SEND_OP:
                        begin
                            cnt8 = state.retry_count[7:0] + 8'd1;
                            s.retry_count = {8'd0, cnt8};
                            if (cnt8 == cfg.cmd1_attempt_limit)
                            begin
                                r.card_select = 1'b0; r.done_res = 1'b1;
                                r.status = ST_CMD1_FAIL; r.busy_res = 1'b0;
                                s.phase = PH_IDLE; s.byte_count = '0;
                            end
                            else
                            begin
                                s.current_command = (miso != 8'd0) ? CMD_SEND_OP
                                                                   : CMD_CRC_ON_OFF;
                                s.phase = PH_CMD; s.byte_count = BC_ONE;
                                r.card_select = 1'b0;
                            end
                        end
                        CMD_CRC_ON_OFF:
                        begin
                            s.current_command = CMD_SET_BLKLEN;
                            s.phase = PH_CMD; s.byte_count = BC_ONE;
                            r.card_select = 1'b0;
                        end
                        CMD_READ_BLOCK:
                        begin
                            s.byte_count = '0;
                            s.phase = PH_TOKEN;
                        end
                        CMD_WRITE_BLK:
                        begin
                            s.retry_count = state.retry_count + 16'd1;
                            if (s.retry_count > {8'd0, cfg.write_command_limit})
                            begin
                                r.card_select = 1'b0; r.done_res = 1'b1;
                                r.status = ST_WCMD_FAIL; r.busy_res = 1'b0;
                                s.phase = PH_IDLE; s.byte_count = '0;
                            end
                            else if (miso != 8'd0)
                            begin
                                s.phase = PH_CMD; s.byte_count = BC_ONE;
                                r.card_select = 1'b0;
                            end
                            else
                            begin
                                s.phase = PH_WPRE; s.byte_count = '0;
                                do_send = 1'b1;
                            end
                        end
                        CMD_SEND_CID:
                        begin
                            s.retry_count = cfg.id_token_poll_limit;
                            s.byte_count = '0;
                            s.phase = PH_IDTOK;
                        end
                        default:
                        begin
                            // Covers the set-block-length reply and anything unexpected.
                            r.card_select = 1'b0; r.done_res = 1'b1;
                            r.busy_res = 1'b0;
                            s.phase = PH_IDLE; s.byte_count = '0;
                        end
                    endcase
                end
            end
            PH_TOKEN:
            begin
                if (miso == START_TOKEN)
                begin
                    s.byte_count = '0;
                    s.phase = PH_DATA;
                end
            end
            PH_IDTOK:
            begin
                if (miso == START_TOKEN)
                begin
                    s.byte_count = '0;
                    s.phase = PH_DATA;
                end
                else
                begin
                    s.retry_count = state.retry_count - 16'd1;
                    if (s.retry_count == 16'd0)
                    begin
                        s.current_command = CMD_SEND_CID;
                        s.phase = PH_CMD; s.byte_count = BC_ONE;
                        r.card_select = 1'b0;
                    end
                end
            end
            PH_DATA:
            begin
                r.data_valid = 1'b1;
                r.data_byte  = miso;
                s.byte_count = state.byte_count + BC_ONE;
                if (s.byte_count < ((state.current_command == CMD_SEND_CID) ? ID_LEN
                                                                           : BLK_LEN))
                begin
                    s.phase = PH_DATA;
                end
                else if (state.current_command == CMD_SEND_CID)
                begin
                    r.card_select = 1'b0; r.done_res = 1'b1;
                    r.busy_res = 1'b0;
                    s.phase = PH_IDLE; s.byte_count = '0;
                end
                else
                begin
                    s.phase = PH_RCRC; s.byte_count = '0;
                    do_send = 1'b1;
                end
            end
            PH_WRESP:
            begin
                s.saved_reply = miso;
                if ((miso & DRESP_MASK) != DRESP_OK)
                begin
                    r.card_select = 1'b0; r.done_res = 1'b1;
                    r.status = ST_DATA_REJ; r.busy_res = 1'b0;
                    s.phase = PH_IDLE; s.byte_count = '0;
                end
                else
                begin
                    s.phase = PH_WBUSY;
                end
            end
            PH_WBUSY:
            begin
                if (miso != 8'd0)
                begin
                    r.card_select = 1'b0; r.done_res = 1'b1;
                    r.busy_res = 1'b0;
                    s.phase = PH_IDLE; s.byte_count = '0;
                end
            end
            default:
            begin
                do_send = 1'b1;
            end
        endcase

        // Transmit side of the sequencer, entered with the phase set above.
        if (do_send)
        begin
            case (s.phase)
                PH_ICLK:
                begin
                    r.card_select = 1'b0;
                    s.byte_count = s.byte_count + BC_ONE;
                    if (s.byte_count >= BC_W'(cfg.init_clock_bytes))
                    begin
                        s.phase = PH_ICMD0;
                    end
                end
                PH_ICMD0:
                begin
                    s.retry_count = 16'd0;
                    s.current_command = CMD_GO_IDLE;
                    s.phase = PH_CMD; s.byte_count = BC_ONE;
                    r.card_select = 1'b0;
                end
                PH_CMD:
                begin
                    if (s.current_command == CMD_SET_BLKLEN)
                    begin
                        arg = BLK_ARG;
                    end
                    else if (s.current_command == CMD_READ_BLOCK ||
                             s.current_command == CMD_WRITE_BLK)
                    begin
                        arg = s.current_sector;
                    end
                    if (s.current_command == CMD_GO_IDLE ||
                        s.current_command == CMD_READ_BLOCK)
                    begin
                        crc = CRC_CMD0;
                    end
                    s.byte_count = s.byte_count + BC_ONE;
                    case (state.byte_count)
                        BC_W'(0): r.card_select = 1'b0;
                        BC_W'(1): r.mosi_byte = CMD_PREFIX | {2'b00, s.current_command};
                        BC_W'(2): r.mosi_byte = arg[31:24];
                        BC_W'(3): r.mosi_byte = arg[23:16];
                        BC_W'(4): r.mosi_byte = arg[15:8];
                        BC_W'(5): r.mosi_byte = arg[7:0];
                        BC_W'(6): r.mosi_byte = crc;
                        BC_W'(7): r.mosi_byte = IDLE_BYTE;
                        default:
                        begin
                            s.phase = PH_RESP;
                            s.byte_count = '0;
                        end
                    endcase
                end
                PH_RCRC:
                begin
                    if (s.byte_count >= BC_ONE)
                    begin
                        s.phase = PH_RDONE;
                    end
                    else
                    begin
                        s.byte_count = s.byte_count + BC_ONE;
                    end
                end
                PH_WPRE:
                begin
                    if (s.byte_count < BC_W'(6))
                    begin
                        s.byte_count = s.byte_count + BC_ONE;
                    end
                    else
                    begin
                        r.mosi_byte = START_TOKEN;
                        s.phase = PH_WDATA; s.byte_count = '0;
                    end
                end
                PH_WDATA:
                begin
                    r.mosi_byte  = item.write_byte;
                    r.byte_taken = 1'b1;
                    s.byte_count = s.byte_count + BC_ONE;
                    if (s.byte_count >= BLK_LEN)
                    begin
                        s.phase = PH_WCRC; s.byte_count = '0;
                    end
                end
                PH_WCRC:
                begin
                    if (s.byte_count >= BC_W'(2))
                    begin
                        s.phase = PH_WRESP;
                    end
                    else
                    begin
                        s.byte_count = s.byte_count + BC_ONE;
                    end
                end
                default:
                begin
                    r.card_select = 1'b0; r.done_res = 1'b1;
                    r.busy_res = 1'b0;
                    s.phase = PH_IDLE; s.byte_count = '0;
                end
            endcase
        end

        r.response = s.saved_reply;
        state_next = s;
        result     = r;
    end

endmodule

`default_nettype wire

FILE: design/sd_spi_mode_host_sequencer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload
// s_*       in         one SPI byte slot: request, sector, write byte, card reply
// m_*       out        byte to send, select, read data, done (tlast) and status
// APB       in/out     six limit registers at byte addresses 0 to 20
//
// Each request goes into an input register and is worked out combinationally into the
// result register, so one request a cycle flows through while the result is not stalled.
// The sequencer state advances only when the input register moves into the result
// register; a stalled result holds the input register and then s_tready.
// Reset clears all control state and loads the register defaults.

module sd_spi_mode_host_sequencer_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // request[2:0], sector[34:3], write_byte[42:35], miso_byte[50:43]
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // mosi_byte[7:0], card_select[8], data_valid[9], data_byte[17:10],
    // byte_taken[18], status[21:19], response[29:22], busy_res[30]
    output logic [31:0]      m_tdata,
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sdsh_pkg::*;

    cfg_t       cfg;
    item_t      item_reg;
    logic       in_valid_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    res_next;
    result_t    res_reg;
    logic       out_valid_reg;
    logic       advance;

    sdsh_cfg_regs u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sdsh_step u_step
    (
        .state      (state_reg),
        .cfg        (cfg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.phase           <= PH_IDLE;
            state_reg.retry_count     <= 16'd0;
            state_reg.byte_count      <= '0;
            state_reg.last_sector     <= 32'hFFFF_FFFF;
            state_reg.current_sector  <= 32'd0;
            state_reg.current_command <= 6'd0;
            state_reg.saved_reply     <= 8'd0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.request    <= s_tdata[2:0];
            item_reg.sector     <= s_tdata[34:3];
            item_reg.write_byte <= s_tdata[42:35];
            item_reg.miso_byte  <= s_tdata[50:43];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_reg.done_res;
    assign m_tdata  = {1'b0, res_reg.busy_res, res_reg.response, res_reg.status,
                       res_reg.byte_taken, res_reg.data_byte, res_reg.data_valid,
                       res_reg.card_select, res_reg.mosi_byte};

endmodule

`default_nettype wire

FILE: design/sdsh_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module sdsh_port_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> !m_tdata[8] && !m_tdata[30] && m_tdata[7:0] == 8'hFF)
        else $error("done slot must release select and clear busy");

    a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[21:19] == 3'd0)
        else $error("status set outside the done slot");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[9] |-> m_tdata[17:10] == 8'd0)
        else $error("read data present without data valid");

    a_busy_select: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[30] |-> !m_tdata[8])
        else $error("select asserted while not busy");

endmodule

bind sd_spi_mode_host_sequencer_unit sdsh_port_checker u_sdsh_port_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
